### rtl/core/rsc_pkg.sv
// Shared widths, codes and handshake structs of the redundant sensor combiner.
package rsc_pkg;

	localparam int VALUE_W    = 16;
	localparam int COUNT_W    = 4;
	localparam int ACC_W      = 40;
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;

	typedef enum logic [1:0] {
		MODE_MAX  = 2'd0,
		MODE_MEAN = 2'd1,
		MODE_RMS  = 2'd2,
		MODE_NONE = 2'd3
	} mode_t;

	typedef enum logic {
		REG_MODE  = 1'b0,
		REG_FLOOR = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic               start;
		logic               do_sqrt;
		logic [ACC_W-1:0]   operand;
		logic [COUNT_W-1:0] divisor;
	} ds_req_t;

	typedef struct packed {
		logic             done;
		logic [ACC_W-1:0] result;
	} ds_rsp_t;

endpackage

### rtl/core/rsc_in_if.sv
// Input channel carrying one sensor reading per item.
interface rsc_in_if;
	import rsc_pkg::*;

	logic                      valid;
	logic                      ready;
	logic                      usable;
	logic signed [VALUE_W-1:0] reading_value;
	logic                      last_reading;

	modport source (output valid, output usable, output reading_value, output last_reading,
		input ready);
	modport sink (input valid, input usable, input reading_value, input last_reading,
		output ready);
endinterface

### rtl/core/rsc_out_if.sv
// Output channel carrying one combined result per item.
interface rsc_out_if;
	import rsc_pkg::*;

	logic                      valid;
	logic                      ready;
	logic signed [VALUE_W-1:0] combined_value;
	logic                      combined_valid;
	logic [COUNT_W-1:0]        used_count;

	modport source (output valid, output combined_value, output combined_valid,
		output used_count, input ready);
	modport sink (input valid, input combined_value, input combined_valid,
		input used_count, output ready);
endinterface

### rtl/core/rsc_divsqrt.sv
// Bit-serial divider by a small count, optionally followed by a bit-serial integer square root.
module rsc_divsqrt (
	input  logic             clk,
	input  logic             arst_n,
	input  rsc_pkg::ds_req_t req,
	output rsc_pkg::ds_rsp_t rsp
);
	import rsc_pkg::*;

	localparam int ROOT_W = ACC_W / 2;
	localparam int REM_W  = ROOT_W + 2;
	localparam int STEP_W = $clog2(ACC_W);

	typedef enum logic [1:0] {U_IDLE, U_DIV, U_SQRT} ustate_t;

	ustate_t            st_q;
	logic [ACC_W-1:0]   sh_q;
	logic [COUNT_W-1:0] drem_q;
	logic [COUNT_W-1:0] dvs_q;
	logic [REM_W-1:0]   srem_q;
	logic [ROOT_W-1:0]  root_q;
	logic [STEP_W-1:0]  step_q;
	logic               sqrt_q;
	logic               done_q;

	logic [COUNT_W:0]   dtrial;
	logic               dfit;
	logic [REM_W+1:0]   stri;
	logic [REM_W+1:0]   strial;
	logic               sfit;

	// One quotient bit per cycle, then two radicand bits per cycle.
	always_comb begin
		dtrial = {drem_q, sh_q[ACC_W-1]};
		dfit   = dtrial >= {1'b0, dvs_q};
		stri   = {srem_q, sh_q[ACC_W-1 -: 2]};
		strial = (REM_W+2)'({root_q, 2'b01});
		sfit   = stri >= strial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= U_IDLE;
			sh_q   <= '0;
			drem_q <= '0;
			dvs_q  <= '0;
			srem_q <= '0;
			root_q <= '0;
			step_q <= '0;
			sqrt_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (st_q)
				U_IDLE: begin
					if (req.start) begin
						sh_q   <= req.operand;
						dvs_q  <= req.divisor;
						sqrt_q <= req.do_sqrt;
						drem_q <= '0;
						step_q <= '0;
						st_q   <= U_DIV;
					end
				end
				U_DIV: begin
					sh_q   <= {sh_q[ACC_W-2:0], dfit};
					drem_q <= dfit ? COUNT_W'(dtrial - {1'b0, dvs_q}) : dtrial[COUNT_W-1:0];
					step_q <= step_q + 1'b1;
					if (step_q == STEP_W'(ACC_W-1)) begin
						step_q <= '0;
						if (sqrt_q) begin
							srem_q <= '0;
							root_q <= '0;
							st_q   <= U_SQRT;
						end else begin
							done_q <= 1'b1;
							st_q   <= U_IDLE;
						end
					end
				end
				U_SQRT: begin
					sh_q   <= {sh_q[ACC_W-3:0], 2'b00};
					srem_q <= sfit ? REM_W'(stri - strial) : REM_W'(stri);
					root_q <= {root_q[ROOT_W-2:0], sfit};
					step_q <= step_q + 1'b1;
					if (step_q == STEP_W'(ROOT_W-1)) begin
						done_q <= 1'b1;
						st_q   <= U_IDLE;
					end
				end
				default: begin
					st_q <= U_IDLE;
				end
			endcase
		end
	end

	assign rsp.done   = done_q;
	assign rsp.result = sqrt_q ? ACC_W'(root_q) : sh_q;

endmodule

### rtl/core/redundant_sensor_combiner.sv
// Throughput: one item per cycle while idle; an RMS-mode reading that exceeds the floor holds
// off further items while the squarer runs. The last item of a set adds the final step: S_FIN
// then S_OUT for max or none, with S_WAIT between them for the mean and RMS, set by the
// bit-serial divider and, for RMS, the root. S_OUT loads the result into the output register.
// arst_n clears the set in progress, the output register and both registers (max mode, floor 0).
// No clearing pass is needed: the block is ready for an item as soon as reset is released.
module redundant_sensor_combiner #(
	parameter int MAX_SENSORS = 8
) (
	input  logic                             clk,
	input  logic                             arst_n,
	rsc_in_if.sink                           in_ch,
	rsc_out_if.source                        out_ch,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [rsc_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [rsc_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [rsc_pkg::APB_DATA_W-1:0]   prdata,
	output logic                             pready
);
	import rsc_pkg::*;

	// The count field is four bits wide, so a set never combines more than fifteen readings.
	localparam int COUNT_CAP = (MAX_SENSORS > 15) ? 15 : MAX_SENSORS;

	typedef enum logic [2:0] {S_IDLE, S_MUL, S_ADD, S_FIN, S_WAIT, S_OUT} state_t;

	function automatic logic signed [VALUE_W-1:0] sat16(input logic signed [41:0] v);
		if (v > 42'sd32767)
			return 16'sh7FFF;
		else if (v < -42'sd32768)
			return 16'sh8000;
		else
			return v[VALUE_W-1:0];
	endfunction

	// Registers written through the APB port.
	mode_t                     mode_q;
	logic signed [VALUE_W-1:0] floor_q;

	// Set state and the nibble-serial squarer.
	state_t                    state_q;
	logic [ACC_W-1:0]          acc_q;
	logic [COUNT_W-1:0]        cnt_q;
	logic                      last_q;
	logic [15:0]               mcand_q;
	logic [15:0]               mplier_q;
	logic [31:0]               prod_q;
	logic [1:0]                dig_q;
	logic                      neg_q;
	logic signed [VALUE_W-1:0] res_q;

	// Output register.
	logic                      out_valid_q;
	logic signed [VALUE_W-1:0] out_value_q;
	logic                      out_cvalid_q;
	logic [COUNT_W-1:0]        out_count_q;

	logic signed [16:0]        excess;
	logic                      excess_pos;
	logic                      take;
	logic [ACC_W-1:0]          rv_ext;
	logic [ACC_W-1:0]          acc_mag;
	logic [19:0]               digit_prod;
	logic [31:0]               prod_next;
	logic signed [41:0]        fin_v;
	logic                      apb_wr;
	ds_req_t                   ds_req;
	ds_rsp_t                   ds_rsp;

	always_comb begin
		rv_ext     = {{(ACC_W-VALUE_W){in_ch.reading_value[VALUE_W-1]}}, in_ch.reading_value};
		excess     = {in_ch.reading_value[VALUE_W-1], in_ch.reading_value}
		           - {floor_q[VALUE_W-1], floor_q};
		excess_pos = !excess[16] && (excess != '0);
		take       = in_ch.usable && (cnt_q < COUNT_W'(COUNT_CAP));
		// The mean divides the magnitude; the sign is put back afterwards, which
		// truncates toward zero.
		acc_mag    = acc_q[ACC_W-1] ? (ACC_W'(0) - acc_q) : acc_q;
		// The squarer takes the multiplier a nibble at a time, most significant first.
		digit_prod = mcand_q * mplier_q[15:12];
		prod_next  = {prod_q[27:0], 4'b0000} + 32'(digit_prod);

		ds_req.start   = (state_q == S_FIN) && (cnt_q != '0)
		               && ((mode_q == MODE_MEAN) || (mode_q == MODE_RMS));
		ds_req.do_sqrt = (mode_q == MODE_RMS);
		ds_req.operand = (mode_q == MODE_MEAN) ? acc_mag : acc_q;
		ds_req.divisor = cnt_q;

		// The root is at most 20 bits wide, so the floor is added without overflow.
		if (mode_q == MODE_RMS)
			fin_v = $signed({2'b00, ds_rsp.result})
			      + {{(42-VALUE_W){floor_q[VALUE_W-1]}}, floor_q};
		else if (neg_q)
			fin_v = 42'sd0 - $signed({2'b00, ds_rsp.result});
		else
			fin_v = $signed({2'b00, ds_rsp.result});

		apb_wr = psel && penable && pwrite && pready;
	end

	rsc_divsqrt u_divsqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (ds_req),
		.rsp    (ds_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= MODE_MAX;
			floor_q      <= '0;
			state_q      <= S_IDLE;
			acc_q        <= '0;
			cnt_q        <= '0;
			last_q       <= 1'b0;
			mcand_q      <= '0;
			mplier_q     <= '0;
			prod_q       <= '0;
			dig_q        <= '0;
			neg_q        <= 1'b0;
			res_q        <= '0;
			out_valid_q  <= 1'b0;
			out_value_q  <= '0;
			out_cvalid_q <= 1'b0;
			out_count_q  <= '0;
		end else begin
			if (apb_wr) begin
				unique case (reg_idx_t'(paddr[2]))
					REG_MODE:  mode_q  <= mode_t'(pwdata[1:0]);
					REG_FLOOR: floor_q <= pwdata[VALUE_W-1:0];
					default:   ;
				endcase
			end

			// A set waiting in S_OUT reloads the output register itself when it drains.
			if (out_valid_q && out_ch.ready && (state_q != S_OUT))
				out_valid_q <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (in_ch.valid) begin
						last_q  <= in_ch.last_reading;
						state_q <= in_ch.last_reading ? S_FIN : S_IDLE;
						if (take) begin
							cnt_q <= cnt_q + 1'b1;
							unique case (mode_q)
								MODE_MAX: begin
									if ((cnt_q == '0) || ($signed(rv_ext) > $signed(acc_q)))
										acc_q <= rv_ext;
								end
								MODE_MEAN: begin
									acc_q <= acc_q + rv_ext;
								end
								MODE_RMS: begin
									// Only a positive excess over the floor is squared.
									if (excess_pos) begin
										mcand_q  <= excess[15:0];
										mplier_q <= excess[15:0];
										prod_q   <= '0;
										dig_q    <= '0;
										state_q  <= S_MUL;
									end
								end
								default: ;
							endcase
						end
					end
				end
				S_MUL: begin
					prod_q   <= prod_next;
					mplier_q <= {mplier_q[11:0], 4'b0000};
					dig_q    <= dig_q + 1'b1;
					if (dig_q == 2'd3)
						state_q <= S_ADD;
				end
				S_ADD: begin
					acc_q   <= acc_q + ACC_W'(prod_q);
					state_q <= last_q ? S_FIN : S_IDLE;
				end
				S_FIN: begin
					priority if ((cnt_q == '0) || (mode_q == MODE_NONE)) begin
						res_q   <= '0;
						state_q <= S_OUT;
					end else if (mode_q == MODE_MAX) begin
						res_q   <= sat16({{2{acc_q[ACC_W-1]}}, acc_q});
						state_q <= S_OUT;
					end else begin
						neg_q   <= acc_q[ACC_W-1];
						state_q <= S_WAIT;
					end
				end
				S_WAIT: begin
					if (ds_rsp.done) begin
						res_q   <= sat16(fin_v);
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					// Wait for the output register to be free, then start a fresh set.
					if (!out_valid_q || out_ch.ready) begin
						out_valid_q  <= 1'b1;
						out_value_q  <= res_q;
						out_cvalid_q <= (cnt_q != '0);
						out_count_q  <= cnt_q;
						acc_q        <= '0;
						cnt_q        <= '0;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_ch.ready           = (state_q == S_IDLE);
	assign out_ch.valid          = out_valid_q;
	assign out_ch.combined_value = out_value_q;
	assign out_ch.combined_valid = out_cvalid_q;
	assign out_ch.used_count     = out_count_q;

	assign pready = 1'b1;
	assign prdata = (reg_idx_t'(paddr[2]) == REG_FLOOR)
	              ? APB_DATA_W'({floor_q})
	              : APB_DATA_W'({mode_q});

endmodule

### rtl/core/rsc_checker.sv
// Port-level assertions for the redundant sensor combiner and the bind that attaches them.
module rsc_checker #(
	parameter int MAX_SENSORS = 8
) (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             out_valid,
	input logic                             out_ready,
	input logic signed [rsc_pkg::VALUE_W-1:0] combined_value,
	input logic                             combined_valid,
	input logic [rsc_pkg::COUNT_W-1:0]      used_count
);
	import rsc_pkg::*;

	localparam int COUNT_CAP = (MAX_SENSORS > 15) ? 15 : MAX_SENSORS;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(combined_value)
			&& $stable(combined_valid) && $stable(used_count))
		else $error("result item changed while stalled");

	a_flag_matches_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (combined_valid == (used_count != '0)))
		else $error("combined_valid disagrees with used_count");

	a_zero_when_none: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !combined_valid |-> (combined_value == '0))
		else $error("value not zero for a set with no usable reading");

	a_count_capped: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (used_count <= COUNT_W'(COUNT_CAP)))
		else $error("used_count above the sensor limit");

endmodule

bind redundant_sensor_combiner rsc_checker #(.MAX_SENSORS(MAX_SENSORS)) u_rsc_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (out_ch.valid),
	.out_ready      (out_ch.ready),
	.combined_value (out_ch.combined_value),
	.combined_valid (out_ch.combined_valid),
	.used_count     (out_ch.used_count)
);

### dv/testbench.sv
// Self-checking testbench for the redundant sensor combiner: stimulus, prediction and checking.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import rsc_pkg::*;

	localparam int MAX_SENSORS      = 8;
	// Usable readings past this count within one set are dropped by the block.
	localparam int COUNT_CAP        = (MAX_SENSORS > 15) ? 15 : MAX_SENSORS;
	localparam int RANDOM_PHASES    = 8;
	localparam int RANDOM_PER_PHASE = 100;
	// The slowest final step is RMS, with the divider, then the root, then the output register;
	// this margin comfortably covers a set still being finished.
	localparam int DRAIN_CYCLES     = 100;
	localparam int CYCLE_LIMIT      = 500000;

	// One sensor reading as the sender presents it. A reading flagged drain_first is held
	// back until every combined result already owed by the block has been collected.
	typedef struct {
		logic                      usable;
		logic signed [VALUE_W-1:0] reading;
		logic                      last;
		bit                        drain_first;
	} reading_item_t;

	// One combined result as the block should return it.
	typedef struct {
		logic signed [VALUE_W-1:0] value;
		logic                      valid;
		logic [COUNT_W-1:0]        count;
	} combined_t;

	logic                  clk;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	rsc_in_if  in_ch();
	rsc_out_if out_ch();

	redundant_sensor_combiner #(
		.MAX_SENSORS(MAX_SENSORS)
	) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready)
	);

	// Readings waiting to be sent, and the combined results the block still owes us.
	reading_item_t pending_readings[$];
	combined_t     expected_results[$];

	// Our own copy of the block's registers and of its per-set accumulation state.
	mode_t                     cur_mode;
	logic signed [VALUE_W-1:0] cur_floor;
	logic [ACC_W-1:0]          acc;
	logic [COUNT_W-1:0]        n_used;

	// Flow-control pressure, as a percentage of cycles, for each side.
	int send_idle_pct;
	int recv_stall_pct;

	int fail_count;
	int readings_accepted;
	int results_checked;
	int settings_applied;
	int cycle_count;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	task automatic report_mismatch(input string msg);
		$display("MISMATCH @%0t: %s", $realtime, msg);
		fail_count++;
	endtask

	// The accumulator holds the running maximum or the running sum as a signed 40-bit value.
	function automatic longint acc_as_signed();
		return longint'(signed'(acc));
	endfunction

	// Integer square root, rounded down, built up one result bit at a time.
	function automatic logic [ACC_W/2-1:0] floor_sqrt(input logic [ACC_W-1:0] x);
		logic [ACC_W/2-1:0] root;
		logic [ACC_W/2-1:0] trial;
		root = '0;
		for (int b = ACC_W/2-1; b >= 0; b--) begin
			trial = root | (ACC_W/2)'(1 << b);
			if (longint'(trial) * longint'(trial) <= longint'(x))
				root = trial;
		end
		return root;
	endfunction

	// Folds one accepted reading into the running state; on the last reading of a set it
	// works out the combined result, queues it and clears the state for the next set.
	function automatic void absorb_reading(input reading_item_t it);
		longint    rv;
		longint    excess;
		longint    res;
		combined_t r;
		rv = it.reading;
		if (it.usable && n_used < COUNT_CAP) begin
			case (cur_mode)
				MODE_MAX: begin
					if (n_used == 0 || rv > acc_as_signed())
						acc = ACC_W'(rv);
				end
				MODE_MEAN: acc = acc + ACC_W'(rv);
				MODE_RMS: begin
					// Only readings above the floor contribute their squared excess.
					excess = rv - longint'(cur_floor);
					if (excess > 0)
						acc = acc + ACC_W'(excess * excess);
				end
				default: ;
			endcase
			n_used++;
		end
		if (!it.last)
			return;

		res = 0;
		if (n_used != 0) begin
			case (cur_mode)
				MODE_MAX:  res = acc_as_signed();
				// Signed division truncates toward zero, as the mean requires.
				MODE_MEAN: res = acc_as_signed() / longint'(n_used);
				MODE_RMS:  res = longint'(floor_sqrt(acc / ACC_W'(n_used))) + longint'(cur_floor);
				default:   res = 0;
			endcase
		end
		if (res > 32767)
			res = 32767;
		else if (res < -32768)
			res = -32768;
		r.value = VALUE_W'(res);
		r.valid = (n_used != 0);
		r.count = n_used;
		expected_results.push_back(r);
		acc    = '0;
		n_used = '0;
	endfunction

	function automatic void queue_reading(input logic u, input logic signed [VALUE_W-1:0] v,
		input logic l, input bit hold = 1'b0);
		reading_item_t it;
		it.usable      = u;
		it.reading     = v;
		it.last        = l;
		it.drain_first = hold;
		pending_readings.push_back(it);
	endfunction

	// Readings drawn from the whole range, from just around the RMS floor, from the
	// extremes, and from the band a coolant sensor really reports (-40 to 150 degrees).
	function automatic logic signed [VALUE_W-1:0] pick_reading();
		int off;
		case ($urandom_range(3))
			0: return VALUE_W'($urandom);
			1: begin
				off = int'($urandom_range(80)) - 40;
				return VALUE_W'(int'(cur_floor) + off);
			end
			2: begin
				case ($urandom_range(3))
					0: return -16'sd32768;
					1: return 16'sd32767;
					2: return 16'sd0;
					default: return -16'sd1;
				endcase
			end
			default: return VALUE_W'(int'($urandom_range(3040)) - 640);
		endcase
	endfunction

	// Queues one complete set and returns its length. Now and then a set is longer than
	// the block will count, so that the cap on usable readings is exercised.
	function automatic int queue_random_set(input bit hold);
		int len;
		len = ($urandom_range(9) == 0) ? int'($urandom_range(12, 9)) : int'($urandom_range(8, 1));
		for (int i = 0; i < len; i++)
			queue_reading($urandom_range(99) < 85, pick_reading(), i == len - 1,
				hold && i == 0);
		return len;
	endfunction

	function automatic void set_flow(input int pattern);
		case (pattern)
			0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
			1: begin send_idle_pct = 81; recv_stall_pct = 0;  end
			2: begin send_idle_pct = 0;  recv_stall_pct = 81; end
			default: begin send_idle_pct = 24; recv_stall_pct = 24; end
		endcase
	endfunction

	task automatic apb_write(input reg_idx_t idx, input logic [APB_DATA_W-1:0] data);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic apb_read(input reg_idx_t idx, output logic [APB_DATA_W-1:0] data);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= {idx, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		data = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// Reads both registers back and compares them with the values we believe they hold.
	task automatic check_registers();
		logic [APB_DATA_W-1:0] data;
		apb_read(REG_MODE, data);
		if (data[1:0] !== cur_mode)
			report_mismatch($sformatf("combine_mode reads %0d, expected %0d", data[1:0], cur_mode));
		apb_read(REG_FLOOR, data);
		if (data[VALUE_W-1:0] !== cur_floor)
			report_mismatch($sformatf("rms_floor reads %0d, expected %0d",
				$signed(data[VALUE_W-1:0]), cur_floor));
	endtask

	// Waits until the block has nothing left to send us, then lets it run on for a while in
	// case it is still finishing a set.
	task automatic settle();
		while (pending_readings.size() != 0 || in_ch.valid || expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Register writes happen only once the block is idle.
	task automatic set_registers(input mode_t m, input logic signed [VALUE_W-1:0] f);
		settle();
		apb_write(REG_MODE, APB_DATA_W'(m));
		apb_write(REG_FLOOR, APB_DATA_W'(f));
		cur_mode  = m;
		cur_floor = f;
		settings_applied++;
		check_registers();
	endtask

	// Sender: keeps valid high until an item is taken, and picks the next item (or a gap)
	// only when the channel is free at this edge.
	always @(posedge clk) begin : reading_driver
		reading_item_t nxt;
		if (arst_n) begin
			if (in_ch.valid && in_ch.ready) begin
				absorb_reading(pending_readings.pop_front());
				readings_accepted++;
			end
			if (!in_ch.valid || in_ch.ready) begin
				if (pending_readings.size() != 0 && $urandom_range(99) >= send_idle_pct &&
					!(pending_readings[0].drain_first && expected_results.size() != 0)) begin
					nxt = pending_readings[0];
					in_ch.valid         <= 1'b1;
					in_ch.usable        <= nxt.usable;
					in_ch.reading_value <= nxt.reading;
					in_ch.last_reading  <= nxt.last;
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: checks each delivered result against the oldest one owed, and throttles
	// ready at random according to the current stall rate.
	always @(posedge clk) begin : result_monitor
		combined_t want;
		if (arst_n) begin
			if (out_ch.valid && out_ch.ready) begin
				if (expected_results.size() == 0) begin
					report_mismatch($sformatf("unexpected result: value %0d valid %0b count %0d",
						out_ch.combined_value, out_ch.combined_valid, out_ch.used_count));
				end else begin
					want = expected_results.pop_front();
					if (out_ch.combined_value !== want.value ||
						out_ch.combined_valid !== want.valid ||
						out_ch.used_count !== want.count)
						report_mismatch($sformatf(
							"result %0d: got value %0d valid %0b count %0d, expected %0d %0b %0d",
							results_checked, out_ch.combined_value, out_ch.combined_valid,
							out_ch.used_count, want.value, want.valid, want.count));
					results_checked++;
				end
			end
			out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk)
		cycle_count <= cycle_count + 1;

	// A hung handshake must not leave the run going forever.
	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT)
			@(posedge clk);
		$display("Timed out after %0d cycles with %0d results still owed.",
			cycle_count, expected_results.size());
		$display("[redundant_sensor_combiner] ERROR");
		$finish;
	end

	initial begin : stimulus
		int made;
		int set_index;
		mode_t m;
		logic signed [VALUE_W-1:0] f;

		arst_n              = 1'b0;
		psel                = 1'b0;
		penable             = 1'b0;
		pwrite              = 1'b0;
		paddr               = '0;
		pwdata              = '0;
		in_ch.valid         = 1'b0;
		in_ch.usable        = 1'b0;
		in_ch.reading_value = '0;
		in_ch.last_reading  = 1'b0;
		out_ch.ready        = 1'b0;
		cur_mode            = MODE_MAX;
		cur_floor           = '0;
		acc                 = '0;
		n_used              = '0;
		fail_count          = 0;
		readings_accepted   = 0;
		results_checked     = 0;
		settings_applied    = 0;
		cycle_count         = 0;
		set_flow(0);

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Straight out of reset the block should report maximum mode and a zero floor.
		check_registers();

		// Maximum over both extremes, with an unusable last reading closing the set; then a
		// set with no usable reading at all, and a single most-negative reading.
		queue_reading(1'b1, -16'sd32768, 1'b0);
		queue_reading(1'b1, 16'sd32767, 1'b0);
		queue_reading(1'b0, 16'sd100, 1'b1);
		queue_reading(1'b0, 16'sd5, 1'b1);
		queue_reading(1'b1, -16'sd32768, 1'b1);

		// Mean: a large positive sum, a negative mean that must truncate toward zero, and a
		// set with more usable readings than the block will count.
		set_registers(MODE_MEAN, 16'sd0);
		queue_reading(1'b1, 16'sd32767, 1'b0);
		queue_reading(1'b1, 16'sd32767, 1'b0);
		queue_reading(1'b1, -16'sd1, 1'b1);
		queue_reading(1'b1, -16'sd7, 1'b0);
		queue_reading(1'b1, 16'sd0, 1'b1);
		for (int i = 0; i < COUNT_CAP; i++)
			queue_reading(1'b1, 16'sd160, 1'b0);
		queue_reading(1'b1, -16'sd32768, 1'b1);

		// RMS: one reading below the floor is left out of the sum but still counted.
		set_registers(MODE_RMS, 16'sd100);
		queue_reading(1'b1, 16'sd50, 1'b0);
		queue_reading(1'b1, 16'sd103, 1'b1);

		// RMS with the floor at each extreme: the largest possible excess, and none at all.
		set_registers(MODE_RMS, -16'sd32768);
		queue_reading(1'b1, 16'sd32767, 1'b1);
		set_registers(MODE_RMS, 16'sd32767);
		queue_reading(1'b1, -16'sd32768, 1'b1);

		// No combining: the value is zero but the count and valid flag still come back.
		set_registers(MODE_NONE, -16'sd1234);
		queue_reading(1'b1, 16'sd1000, 1'b0);
		queue_reading(1'b1, -16'sd5, 1'b1);

		// Random phases, each with its own register setting and flow-control pattern.
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			case (p)
				0: begin m = MODE_MAX;  f = VALUE_W'($urandom);  end
				1: begin m = MODE_MEAN; f = VALUE_W'($urandom);  end
				2: begin m = MODE_RMS;  f = 16'sd0;              end
				3: begin m = MODE_NONE; f = VALUE_W'($urandom);  end
				4: begin m = MODE_RMS;  f = -16'sd32768;         end
				5: begin m = MODE_RMS;  f = 16'sd32767;          end
				6: begin m = MODE_RMS;  f = VALUE_W'(int'($urandom_range(1600)) - 160); end
				default: begin
					m = mode_t'($urandom_range(3));
					f = VALUE_W'($urandom);
				end
			endcase
			set_registers(m, f);
			set_flow(p % 4);
			made      = 0;
			set_index = 0;
			// Every tenth set, and the odd one at random, waits for the block to drain first.
			while (made < RANDOM_PER_PHASE) begin
				made += queue_random_set((set_index % 10) == 5 || $urandom_range(99) < 3);
				set_index++;
			end
		end

		settle();

		$display("Checked %0d combined results from %0d readings under %0d register settings,",
			results_checked, readings_accepted, settings_applied + 1);
		$display("with the sender and receiver idling in four different patterns.");
		if (fail_count == 0) begin
			$display("[redundant_sensor_combiner] OK");
		end else begin
			$display("%0d mismatches found.", fail_count);
			$display("[redundant_sensor_combiner] ERROR");
		end
		$finish;
	end

endmodule
